[src/bse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int unsigned GQ_DEPTH = 2;
    localparam int unsigned GQ_PTR_W = (GQ_DEPTH > 1) ? $clog2(GQ_DEPTH) : 1;
    localparam int unsigned GQ_CNT_W = $clog2(GQ_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    localparam logic [1:0] CHAR_POS_0 = 2'd0;
    localparam logic [1:0] CHAR_POS_1 = 2'd1;
    localparam logic [1:0] CHAR_POS_2 = 2'd2;
    localparam logic [1:0] CHAR_POS_3 = 2'd3;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       last;
    } t_group;

    typedef struct packed {
        logic empty;
        logic full;
    } t_gq_status;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

[src/bse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_front
// Collects input bytes into groups of up to three and hands each closed
// group to the group queue.
// ----------------------------------------------------------------------------
module bse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_data_byte,
    input  logic            i_msg_end,
    input  logic            i_gq_full,
    output logic            o_full,
    output logic            o_grp_push,
    output bse_pkg::t_group o_grp
);
    import bse_pkg::*;

    logic [7:0] r_held [2];
    logic [7:0] n_held [2];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       accept;

    assign o_full = i_gq_full;
    assign accept = i_push && !i_gq_full;

    always_comb begin
        n_held     = r_held;
        n_count    = r_count;
        o_grp_push = 1'b0;
        o_grp      = '{b0: i_data_byte, b1: 8'd0, b2: 8'd0, nbytes: NBYTES_ONE,
                       last: i_msg_end};
        case (r_count)
            2'd0: begin
                if (accept) begin
                    if (i_msg_end) begin
                        o_grp_push = 1'b1;
                    end else begin
                        n_held[0] = i_data_byte;
                        n_count   = 2'd1;
                    end
                end
            end
            2'd1: begin
                o_grp.b0     = r_held[0];
                o_grp.b1     = i_data_byte;
                o_grp.nbytes = NBYTES_TWO;
                if (accept) begin
                    if (i_msg_end) begin
                        o_grp_push = 1'b1;
                        n_count    = 2'd0;
                    end else begin
                        n_held[1] = i_data_byte;
                        n_count   = 2'd2;
                    end
                end
            end
            default: begin
                o_grp.b0     = r_held[0];
                o_grp.b1     = r_held[1];
                o_grp.b2     = i_data_byte;
                o_grp.nbytes = NBYTES_THREE;
                if (accept) begin
                    o_grp_push = 1'b1;
                    n_count    = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[src/bse_gq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_gq
// Short queue of closed byte groups between the front and the back end.
// ----------------------------------------------------------------------------
module bse_gq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bse_pkg::t_group    i_data,
    input  logic               i_pop,
    output bse_pkg::t_group    o_data,
    output bse_pkg::t_gq_status o_status
);
    import bse_pkg::*;

    t_group              r_mem [GQ_DEPTH];
    logic [GQ_PTR_W-1:0] r_wr_ptr;
    logic [GQ_PTR_W-1:0] r_rd_ptr;
    logic [GQ_CNT_W-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.empty = (r_count == GQ_CNT_W'(0));
    assign o_status.full  = (r_count == GQ_CNT_W'(GQ_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    function automatic logic [GQ_PTR_W-1:0] ptr_inc(input logic [GQ_PTR_W-1:0] p);
        logic [GQ_PTR_W-1:0] r;
        if (p == GQ_PTR_W'(GQ_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + GQ_PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + GQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - GQ_CNT_W'(1);
            end
        end
    end

endmodule

[src/bse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_back
// Turns the queue's head group into four characters, one per cycle while it
// is queued and the output is popped or empty, into a registered output stage.
// ----------------------------------------------------------------------------
module bse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bse_pkg::t_group     i_grp,
    input  bse_pkg::t_gq_status i_gq_status,
    output logic                o_gq_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);
    import bse_pkg::*;

    logic [1:0] r_pos;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    logic [7:0] n_char;

    assign load     = !i_gq_status.empty && (!r_valid || i_pop);
    assign o_gq_pop = load && (r_pos == CHAR_POS_3);

    always_comb begin
        sextet = i_grp.b2[5:0];
        pad    = 1'b0;
        case (r_pos)
            CHAR_POS_0: sextet = i_grp.b0[7:2];
            CHAR_POS_1: sextet = {i_grp.b0[1:0], i_grp.b1[7:4]};
            CHAR_POS_2: begin
                sextet = {i_grp.b1[3:0], i_grp.b2[7:6]};
                pad    = (i_grp.nbytes < NBYTES_TWO);
            end
            default: begin
                sextet = i_grp.b2[5:0];
                pad    = (i_grp.nbytes < NBYTES_THREE);
            end
        endcase
        n_char = pad ? PAD_CHAR : sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= i_grp.last && (r_pos == CHAR_POS_3);
        end
        if (!i_rst_n) begin
            r_pos   <= CHAR_POS_0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos   <= r_pos + 2'd1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

[src/base64_stream_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: raw bytes in, base64 characters out.
// ----------------------------------------------------------------------------
// Bytes are pushed one per beat with msg_end on the final byte of a message.
// Every third byte, or the final byte, closes a group that yields four
// characters, padded with '=' where the group holds fewer than three bytes;
// the fourth character of the final group carries last_char. A byte is taken
// in the cycle it is pushed unless the two-entry group queue is full, and the
// character stage delivers one character per cycle while pop is held high and
// a group is queued, so the sustained rate is four characters per three input
// bytes, set by the single character output register. A short final group
// still yields four characters. Once its closing byte is accepted, a group is
// registered in the group queue and its first character then in the character
// output register when the character stage is free.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_msg_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);
    import bse_pkg::*;

    t_group     grp_in;
    t_group     grp_head;
    t_gq_status gq_st;
    logic       grp_push;
    logic       gq_pop;

    bse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_msg_end   (i_msg_end),
        .i_gq_full   (gq_st.full),
        .o_full      (full),
        .o_grp_push  (grp_push),
        .o_grp       (grp_in)
    );

    bse_gq u_gq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (grp_push),
        .i_data   (grp_in),
        .i_pop    (gq_pop),
        .o_data   (grp_head),
        .o_status (gq_st)
    );

    bse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp_head),
        .i_gq_status (gq_st),
        .o_gq_pop    (gq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!gq_st.empty && empty) |=> !empty)
        else $error("queued group not moved to the character stage");

    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_out_char == PAD_CHAR && !o_last_char)
        |=> (!empty && o_out_char == PAD_CHAR && o_last_char))
        else $error("padding not closed by a final padding character");

endmodule
